[rtl/html_tag_strip_entity_expand_macros.svh]
// Assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef HTML_TAG_STRIP_ENTITY_EXPAND_MACROS_SVH
`define HTML_TAG_STRIP_ENTITY_EXPAND_MACROS_SVH

// Same-cycle implication.
`define HTSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htse: check failed");

// Next-cycle implication.
`define HTSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htse: check failed");

`endif

[rtl/htse_pkg.sv]
package htse_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       nl;
    logic       last;
  } tok_t;

  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [15:0] LIMIT_RESET = 16'd32767;

  localparam logic [7:0] ENT_STR [6][6] = '{
    '{"&", "a", "m", "p", ";", 8'h00},
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"&", "n", "b", "s", "p", ";"},
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "#", "3", "9", ";", 8'h00}
  };
  localparam logic [2:0] ENT_LEN [6] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5};
  localparam logic [7:0] ENT_OUT [6] = '{8'h26, 8'h3C, 8'h3E, 8'h20, 8'h22, 8'h27};

  localparam logic [7:0] OPEN_STR [2][6] = '{
    '{"s", "c", "r", "i", "p", "t"},
    '{"s", "t", "y", "l", "e", 8'h00}
  };
  localparam logic [3:0] OPEN_LEN [2] = '{4'd6, 4'd5};

  localparam logic [7:0] CLOSE_STR [2][8] = '{
    '{"<", "/", "s", "c", "r", "i", "p", "t"},
    '{"<", "/", "s", "t", "y", "l", "e", 8'h00}
  };
  localparam logic [3:0] CLOSE_LEN [2] = '{4'd8, 4'd7};

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

[rtl/htse_ifs.sv]
interface htse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface htse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_empty;
  logic       out_last;
  modport source (output valid, out_byte, out_empty, out_last, input ready);
  modport sink   (input valid, out_byte, out_empty, out_last, output ready);
endinterface

[rtl/htse_fifo.sv]
module htse_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htse_pkg::tok_t din,
  output logic          full,
  input  logic          pop,
  output htse_pkg::tok_t dout,
  output logic          empty
);
  import htse_pkg::*;

  localparam int unsigned AW = $clog2(QDEPTH);

  tok_t            mem_r [QDEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= din;
  end

endmodule

[rtl/htse_front.sv]
module htse_front #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  htse_in_if.sink        in_ch,
  input  logic [15:0]    output_limit,
  output htse_pkg::tok_t tok,
  output logic           tok_push,
  input  logic           tok_full
);
  import htse_pkg::*;

  localparam int unsigned CMPW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  typedef enum logic [2:0] {
    MODE_TEXT, MODE_LT, MODE_SECOND, MODE_OPENNAME, MODE_TAG, MODE_SKIP, MODE_CLOSE
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [7:0]            tfc_r, tfc_nxt;
  logic [3:0]            cpos_r, cpos_nxt;
  logic [1:0]            ccand_r, ccand_nxt;
  logic [7:0]            prev_r, prev_nxt;
  logic [COUNT_BITS-1:0] kc_r, kc_nxt;

  logic                  acc, run;
  logic [7:0]            c, cl, tc, p0;
  logic                  keep_a, keep_b, hdr, nl;
  logic [7:0]            ch_a;
  logic [COUNT_BITS-1:0] kc_mid;
  logic                  k;
  logic [3:0]            posn;
  logic [1:0]            live;
  logic                  done;

  function automatic logic can_keep(input logic [COUNT_BITS-1:0] kc, input logic [15:0] lim);
    return ((CMPW'(kc) + CMPW'(1)) < CMPW'(lim)) && (kc != '1);
  endfunction

  assign in_ch.ready = !tok_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign cl          = to_lower(c);

  always_comb begin
    mode_nxt  = mode_r;
    tfc_nxt   = tfc_r;
    cpos_nxt  = cpos_r;
    ccand_nxt = ccand_r;
    prev_nxt  = prev_r;
    kc_nxt    = kc_r;
    keep_a    = 1'b0;
    keep_b    = 1'b0;
    ch_a      = CH_NL;
    tc        = c;
    p0        = to_lower(tfc_r);
    hdr       = 1'b0;
    nl        = 1'b0;
    kc_mid    = kc_r;
    k         = 1'b0;
    posn      = cpos_r + 4'd1;
    live      = 2'b00;
    done      = 1'b0;
    run       = acc && can_keep(kc_r, output_limit);

    if (run) begin
      case (mode_r)
        MODE_TEXT: begin
          if (c == CH_LT) begin
            mode_nxt = MODE_LT;
          end else begin
            if (c == CH_TAB || c == CH_CR) tc = CH_SP;
            if (!(tc == CH_SP && kc_r != '0 && prev_r == CH_SP)) begin
              keep_a = 1'b1;
              ch_a   = tc;
            end
          end
        end
        MODE_LT: begin
          if (c == CH_GT) begin
            mode_nxt = MODE_TEXT;
          end else begin
            tfc_nxt  = c;
            mode_nxt = MODE_SECOND;
          end
        end
        MODE_SECOND: begin
          hdr = (p0 == "h") && (c >= "1") && (c <= "6");
          nl  = (p0 == "b" && cl == "r") ||
                (p0 == "p" && (c == CH_GT || c == CH_SP || c == CH_SLASH)) ||
                (p0 == "d") || hdr || (p0 == "l" && cl == "i") || (p0 == "t" && cl == "r");
          keep_a = nl && kc_r != '0 && prev_r != CH_NL;
          kc_mid = kc_r + COUNT_BITS'(keep_a);
          keep_b = hdr && can_keep(kc_mid, output_limit);
          if (c == CH_GT) begin
            mode_nxt = MODE_TEXT;
          end else if (p0 == "s" && (cl == "c" || cl == "t")) begin
            ccand_nxt = (cl == "c") ? 2'd1 : 2'd2;
            cpos_nxt  = 4'd2;
            mode_nxt  = MODE_OPENNAME;
          end else begin
            mode_nxt = MODE_TAG;
          end
        end
        MODE_OPENNAME: begin
          k = (ccand_r == 2'd2);
          if (cpos_r < OPEN_LEN[k] && cl == OPEN_STR[k][cpos_r[2:0]]) begin
            cpos_nxt = posn;
            if (posn == OPEN_LEN[k]) begin
              mode_nxt  = MODE_SKIP;
              cpos_nxt  = 4'd0;
              ccand_nxt = 2'b11;
            end
          end else begin
            mode_nxt  = (c == CH_GT) ? MODE_TEXT : MODE_TAG;
            cpos_nxt  = 4'd0;
            ccand_nxt = 2'b11;
          end
        end
        MODE_SKIP: begin
          if (c == CH_LT) begin
            mode_nxt  = MODE_CLOSE;
            cpos_nxt  = 4'd1;
            ccand_nxt = 2'b11;
          end
        end
        MODE_CLOSE: begin
          for (int i = 0; i < 2; i++) begin
            if (ccand_r[i] && cpos_r < CLOSE_LEN[i] && cl == CLOSE_STR[i][cpos_r[2:0]]) begin
              live[i] = 1'b1;
              if (posn == CLOSE_LEN[i]) done = 1'b1;
            end
          end
          if (done) begin
            mode_nxt  = MODE_TAG;
            cpos_nxt  = 4'd0;
            ccand_nxt = 2'b11;
          end else if (live != 2'b00) begin
            cpos_nxt  = posn;
            ccand_nxt = live;
          end else begin
            ccand_nxt = 2'b11;
            if (c == CH_LT) begin
              cpos_nxt = 4'd1;
            end else begin
              cpos_nxt = 4'd0;
              mode_nxt = MODE_SKIP;
            end
          end
        end
        MODE_TAG: begin
          if (c == CH_GT) mode_nxt = MODE_TEXT;
        end
        default: mode_nxt = MODE_TEXT;
      endcase
      if (keep_b)      prev_nxt = CH_NL;
      else if (keep_a) prev_nxt = ch_a;
      kc_nxt = kc_r + COUNT_BITS'(keep_a) + COUNT_BITS'(keep_b);
    end

    if (acc && in_ch.in_last) begin
      mode_nxt  = MODE_TEXT;
      tfc_nxt   = 8'd0;
      cpos_nxt  = 4'd0;
      ccand_nxt = 2'b11;
      prev_nxt  = 8'd0;
      kc_nxt    = '0;
    end

    tok.ch   = keep_a ? ch_a : CH_NL;
    tok.has  = keep_a || keep_b;
    tok.nl   = keep_a && keep_b;
    tok.last = in_ch.in_last;
    tok_push = acc && (keep_a || keep_b || in_ch.in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      tfc_r   <= 8'd0;
      cpos_r  <= 4'd0;
      ccand_r <= 2'b11;
      prev_r  <= 8'd0;
      kc_r    <= '0;
    end else begin
      mode_r  <= mode_nxt;
      tfc_r   <= tfc_nxt;
      cpos_r  <= cpos_nxt;
      ccand_r <= ccand_nxt;
      prev_r  <= prev_nxt;
      kc_r    <= kc_nxt;
    end
  end

endmodule

[rtl/htse_back.sv]
module htse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  htse_pkg::tok_t q_tok,
  input  logic           q_empty,
  output logic           q_pop,
  htse_out_if.source     out_ch
);
  import htse_pkg::*;

  typedef enum logic [1:0] {PH_CHAR, PH_FLUSH, PH_END} phase_t;

  phase_t     phase_r, phase_nxt;
  logic       cur_v_r, cur_v_nxt;
  logic [7:0] cur_ch_r, cur_ch_nxt;
  logic       cur_nl_r, cur_nl_nxt;
  logic       cur_last_r, cur_last_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] pend_r [5];
  logic [2:0] plen_r, plen_nxt;
  logic [5:0] cand_r, cand_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_empty_r, out_empty_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free, step, fin, consumed, load;
  logic       emit, e_empty, e_last;
  logic [7:0] e_byte;
  logic       pend_we;
  logic [2:0] pend_wa;
  logic [5:0] m, dn;
  logic [7:0] dn_out;

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.out_empty = out_empty_r;
  assign out_ch.out_last  = out_last_r;
  assign out_free         = !out_v_r || out_ch.ready;
  assign step             = cur_v_r && out_free;

  always_comb begin
    m      = '0;
    dn     = '0;
    dn_out = 8'd0;
    for (int e = 0; e < 6; e++) begin
      if (cand_r[e] && plen_r < ENT_LEN[e] && ENT_STR[e][plen_r] == cur_ch_r) begin
        m[e] = 1'b1;
        if (plen_r + 3'd1 == ENT_LEN[e]) begin
          dn[e]  = 1'b1;
          dn_out = ENT_OUT[e];
        end
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    cur_v_nxt    = cur_v_r;
    cur_ch_nxt   = cur_ch_r;
    cur_nl_nxt   = cur_nl_r;
    cur_last_nxt = cur_last_r;
    idx_nxt      = idx_r;
    plen_nxt     = plen_r;
    cand_nxt     = cand_r;
    emit         = 1'b0;
    e_byte       = 8'd0;
    e_empty      = 1'b0;
    e_last       = 1'b0;
    fin          = 1'b0;
    consumed     = 1'b0;
    pend_we      = 1'b0;
    pend_wa      = plen_r;

    if (step) begin
      unique case (phase_r)
        PH_CHAR: begin
          if (plen_r == 3'd0) begin
            consumed = 1'b1;
            if (cur_ch_r == CH_AMP) begin
              pend_we  = 1'b1;
              plen_nxt = 3'd1;
              cand_nxt = 6'h3F;
            end else begin
              emit   = 1'b1;
              e_byte = cur_ch_r;
            end
          end else if (dn != '0) begin
            consumed = 1'b1;
            emit     = 1'b1;
            e_byte   = dn_out;
            plen_nxt = 3'd0;
            cand_nxt = '0;
          end else if (m != '0) begin
            consumed = 1'b1;
            pend_we  = 1'b1;
            plen_nxt = plen_r + 3'd1;
            cand_nxt = m;
          end else begin
            phase_nxt = PH_FLUSH;
            idx_nxt   = 3'd0;
          end
          if (consumed) begin
            if (cur_nl_r) begin
              cur_ch_nxt = CH_NL;
              cur_nl_nxt = 1'b0;
            end else if (!cur_last_r) begin
              fin = 1'b1;
            end else if (plen_nxt == 3'd0) begin
              fin    = 1'b1;
              e_last = 1'b1;
            end else begin
              phase_nxt = PH_END;
              idx_nxt   = 3'd0;
            end
          end
        end
        PH_FLUSH: begin
          emit   = 1'b1;
          e_byte = pend_r[idx_r];
          if (idx_r + 3'd1 == plen_r) begin
            plen_nxt  = 3'd0;
            cand_nxt  = '0;
            idx_nxt   = 3'd0;
            phase_nxt = PH_CHAR;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_END: begin
          emit = 1'b1;
          if (plen_r == 3'd0) begin
            e_empty = 1'b1;
            e_last  = 1'b1;
            fin     = 1'b1;
          end else begin
            e_byte = pend_r[idx_r];
            if (idx_r + 3'd1 == plen_r) begin
              e_last   = 1'b1;
              fin      = 1'b1;
              plen_nxt = 3'd0;
              cand_nxt = '0;
              idx_nxt  = 3'd0;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
        default: phase_nxt = PH_CHAR;
      endcase
    end

    load  = !cur_v_r || fin;
    q_pop = load && !q_empty;
    if (q_pop) begin
      cur_v_nxt    = 1'b1;
      cur_ch_nxt   = q_tok.ch;
      cur_nl_nxt   = q_tok.nl;
      cur_last_nxt = q_tok.last;
      phase_nxt    = q_tok.has ? PH_CHAR : PH_END;
      idx_nxt      = 3'd0;
    end else if (fin) begin
      cur_v_nxt = 1'b0;
    end

    out_v_nxt     = out_v_r;
    out_byte_nxt  = out_byte_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_v_nxt     = 1'b1;
      out_byte_nxt  = e_byte;
      out_empty_nxt = e_empty;
      out_last_nxt  = e_last;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CHAR;
      cur_v_r <= 1'b0;
      idx_r   <= 3'd0;
      plen_r  <= 3'd0;
      cand_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
      plen_r  <= plen_nxt;
      cand_r  <= cand_nxt;
      out_v_r <= out_v_nxt;
    end
    cur_ch_r    <= cur_ch_nxt;
    cur_nl_r    <= cur_nl_nxt;
    cur_last_r  <= cur_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
    if (pend_we) pend_r[pend_wa] <= cur_ch_r;
  end

endmodule

[rtl/html_tag_strip_entity_expand.sv]
// HTML to plain text, one document byte per beat on in_ch, text bytes on out_ch.
// The parser takes a byte every cycle while its four-entry queue has room; the
// decoder behind it sends at most one output byte per cycle from its output register while out_ch is ready.
// An entity prefix that fails to match is sent from its buffer (up to five bytes)
// before the failing byte is retried, and a prefix still buffered at in_last is
// sent after it, with out_last set on the final byte of the prefix.
// A document that yields no text ends with one beat that has out_empty and
// out_last set.
// The user writes output_limit through cfg_we/cfg_wdata only while no document is in flight; not enforced.
module html_tag_strip_entity_expand #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  htse_in_if.sink     in_ch,
  htse_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import htse_pkg::*;

  logic [15:0] limit_r;
  tok_t        f_tok, q_tok;
  logic        f_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  htse_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .output_limit (limit_r),
    .tok          (f_tok),
    .tok_push     (f_push),
    .tok_full     (q_full)
  );

  htse_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_tok),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_tok),
    .empty (q_empty)
  );

  htse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_tok   (q_tok),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[rtl/htse_checker.sv]
`include "html_tag_strip_entity_expand_macros.svh"

module htse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_empty,
  input logic       out_last
);

  logic [3:0] docs_r, docs_nxt;
  logic       in_end, out_end;
  logic [9:0] out_pay;

  assign in_end  = in_valid && in_ready && in_last;
  assign out_end = out_valid && out_ready && out_last;
  assign out_pay = {out_byte, out_empty, out_last};

  always_comb begin
    docs_nxt = docs_r + 4'(in_end) - 4'(out_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      docs_r <= 4'd0;
    end else begin
      docs_r <= docs_nxt;
    end
  end

  `HTSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pay))
  `HTSE_ASSERT_IMP(a_empty_is_end, out_valid && out_empty, out_last && out_byte == 8'd0)
  `HTSE_ASSERT_IMP(a_end_has_doc, out_end, docs_r != 4'd0)

endmodule

bind html_tag_strip_entity_expand htse_checker u_htse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_empty (out_ch.out_empty),
  .out_last  (out_ch.out_last)
);
